FILE: rtl/hpdec_pkg.sv
package hpdec_pkg;

  localparam int QDEPTH  = 4;
  localparam int MAX_RES = 3;
  localparam int CW      = $clog2(QDEPTH + 1);

  localparam logic [4:0] MAX_CODE_BITS = 5'd30;
  localparam logic [4:0] MAX_PAD_BITS  = 5'd7;

  typedef enum logic [1:0] {
    KIND_SYM  = 2'd0,
    KIND_OK   = 2'd1,
    KIND_LONG = 2'd2,
    KIND_PAD  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] sym;
    logic       last;
  } res_t;

  typedef struct packed {
    logic                     en;
    logic [1:0]               n;
    res_t [MAX_RES-1:0]       res;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] sym;
  } match_t;

  localparam logic [29:0] CODE_TAB [128] = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
    30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
    30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
    30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
    30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
    30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
    30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
    30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
    30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ffb, 30'h15, 30'hf8, 30'hffb,
    30'h3fa, 30'h3fb, 30'hf9, 30'hffc, 30'hfa, 30'h16, 30'h17, 30'h18,
    30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
    30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffd, 30'h3fc,
    30'h1ffc, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
    30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
    30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
    30'hfc, 30'h73, 30'hfd, 30'h1ffd, 30'h7fff0, 30'h1ffe, 30'h3ffc, 30'h22,
    30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
    30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
    30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
    30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1fff, 30'hffffffc
  };

  localparam logic [4:0] LEN_TAB [128] = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd12,
    5'd10, 5'd10, 5'd8, 5'd12, 5'd8, 5'd6, 5'd6, 5'd6,
    5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
    5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
    5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
    5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
    5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
    5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28
  };

  // parallel compare against every code of the table
  function automatic match_t match_code(input logic [29:0] acc, input logic [4:0] len);
    match_t r;
    r = '0;
    for (int s = 0; s < 128; s++) begin
      if (LEN_TAB[s] == len && CODE_TAB[s] == acc) begin
        r.hit = 1'b1;
        r.sym = 7'(s);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/hpdec_core.sv
module hpdec_core
  import hpdec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic [CW-1:0] q_free,
  output push_t         push
);

  logic        full;
  logic [7:0]  byte_q;
  logic        last_q;

  logic [29:0] acc;
  logic [4:0]  cnt;
  logic        disc;

  logic [29:0] acc_next;
  logic [4:0]  cnt_next;
  logic        disc_next;
  logic [1:0]  n;
  res_t [MAX_RES-1:0] res;
  logic        stop;
  match_t      m;
  logic [7:0]  pad_mask;
  logic        advance;

  // eight bit steps, one byte per pass
  always_comb begin
    acc_next  = acc;
    cnt_next  = cnt;
    disc_next = disc;
    n         = '0;
    res       = '0;
    stop      = disc;
    m         = '0;
    pad_mask  = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!stop) begin
        if (cnt_next >= MAX_CODE_BITS) begin
          if (n < 2'd3) begin
            res[n].kind = KIND_LONG;
          end
          n         = n + 2'd1;
          disc_next = 1'b1;
          stop      = 1'b1;
        end else begin
          acc_next = {acc_next[28:0], byte_q[b]};
          cnt_next = cnt_next + 5'd1;
          m        = match_code(acc_next, cnt_next);
          if (m.hit) begin
            if (n < 2'd3) begin
              res[n].kind = KIND_SYM;
              res[n].sym  = m.sym;
            end
            n        = n + 2'd1;
            acc_next = '0;
            cnt_next = '0;
          end
        end
      end
    end
    if (last_q) begin
      if (!disc_next) begin
        pad_mask = 8'((9'd1 << cnt_next[2:0]) - 9'd1);
        if (n < 2'd3) begin
          if (cnt_next > MAX_PAD_BITS || (acc_next[7:0] & pad_mask) != pad_mask) begin
            res[n].kind = KIND_PAD;
          end else begin
            res[n].kind = KIND_OK;
          end
        end
        n = n + 2'd1;
      end
      acc_next  = '0;
      cnt_next  = '0;
      disc_next = 1'b0;
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  assign advance  = full && ({{(CW-2){1'b0}}, n} <= q_free);
  assign in_stall = full && !advance;

  assign push.en  = advance;
  assign push.n   = n;
  assign push.res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      acc  <= '0;
      cnt  <= '0;
      disc <= 1'b0;
    end else begin
      if (!in_stall) begin
        full <= in_valid;
      end
      if (advance) begin
        acc  <= acc_next;
        cnt  <= cnt_next;
        disc <= disc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
  end

endmodule

FILE: rtl/hpdec_outq.sv
module hpdec_outq
  import hpdec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  push_t         push,
  output logic [CW-1:0] q_free,
  output logic          out_valid,
  input  logic          out_stall,
  output res_t          head
);

  res_t [QDEPTH-1:0] ent;
  res_t [QDEPTH-1:0] ent_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     keep;
  logic [CW-1:0]     j;
  logic              pop;

  assign pop       = (count != '0) && !out_stall;
  assign keep      = count - CW'(pop);
  assign out_valid = (count != '0);
  assign head      = ent[0];
  assign q_free    = CW'(QDEPTH) - count;

  // shift-down queue; head always sits in entry 0
  always_comb begin
    ent_next = ent;
    j        = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      if (CW'(i) < keep) begin
        if (pop && i < QDEPTH - 1) begin
          ent_next[i] = ent[i + 1];
        end
      end else begin
        j = CW'(i) - keep;
        if (push.en && j < CW'(push.n) && j < CW'(MAX_RES)) begin
          ent_next[i] = push.res[j[1:0]];
        end
      end
    end
    count_next = keep + (push.en ? CW'(push.n) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

FILE: rtl/hpack_huffman_string_decoder.sv
// HPACK Huffman string decoder, one coded byte per item.
//
// Input channel: data_byte with last_byte (end of string), taken when in_valid
// is high and in_stall is low. Output channel: one result per item on kind,
// symbol and last_result, taken when out_valid is high and out_stall is low.
// kind: decoded symbol, string ended ok, code too long, or bad padding.
// last_result flags the final result caused by one input byte.
//
// Throughput: one byte per cycle while its results fit in the queue; all
// eight bits are decoded in one pass through the input register's decode
// logic. A byte yields at most three results (two symbols plus an end or
// error result), and the output channel drains one per cycle while out_stall
// is low, so bytes that yield several results can fill the queue and hold the
// input. The four-entry result queue lets a new byte be taken while earlier
// results still wait at the output.
//
// Reset clears the code accumulator, bit count and discard flag, empties the
// queue and drops any byte held in the input register.
// When the receiver stalls, the queue fills; once a decoded byte's results do
// not fit, in_stall rises and the held byte waits.
module hpack_huffman_string_decoder
  import hpdec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [6:0] symbol,
  output logic       last_result
);

  push_t         push;
  logic [CW-1:0] q_free;
  res_t          head;

  // byte register plus eight-step decode against the code table
  hpdec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_free    (q_free),
    .push      (push)
  );

  // result queue, up to three pushed per cycle, one popped while out_stall is low
  hpdec_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_free    (q_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind        = head.kind;
  assign symbol      = head.sym;
  assign last_result = head.last;

endmodule

FILE: rtl/hpdec_checker.sv
module hpdec_checker
  import hpdec_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] data_byte,
  input logic       last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [6:0] symbol,
  input logic       last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(symbol)
      && $stable(last_result))
    else $error("stalled result changed");

  a_sym_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SYM |-> symbol == 7'd0)
    else $error("symbol not zero on status result");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SYM |-> last_result)
    else $error("status result not last of its byte");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind hpack_huffman_string_decoder hpdec_checker u_hpdec_checker (.*);
